@@ hw/rtl/thpwl_pkg.sv @@
package thpwl_pkg;

   // Fixed field widths
   localparam int OFFSET_BITS     = 21;
   localparam int SITE_W_BITS     = 16;
   localparam int HPWL_OUT_BITS   = 33;
   localparam int SITES_BITS      = 62;
   localparam int TOTAL_BITS      = 63;
   localparam int QUEUE_DEPTH     = 4;
   localparam int FLAG_BITS       = 3;

   localparam logic [SITE_W_BITS-1:0]   SITE_W_RESET = SITE_W_BITS'(1);
   localparam logic [HPWL_OUT_BITS-1:0] HPWL_MAX     = {HPWL_OUT_BITS{1'b1}};
   localparam logic [SITES_BITS-1:0]    SITES_MAX    = {SITES_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0]    TOTAL_MAX    = {TOTAL_BITS{1'b1}};

   // Per-item control flags handed from the front end to the back end
   typedef struct packed {
      logic has_pin;
      logic net_close;
      logic design_end;
   } item_flags_type;

endpackage

@@ hw/rtl/thpwl_if.sv @@
// Pin item channel
interface thpwl_req_if #(parameter int COORD_BITS = 31);
   logic                                   valid;
   logic                                   ready;
   logic signed [COORD_BITS-1:0]           node_x;
   logic signed [COORD_BITS-1:0]           node_y;
   logic signed [thpwl_pkg::OFFSET_BITS-1:0] pin_dx;
   logic signed [thpwl_pkg::OFFSET_BITS-1:0] pin_dy;
   logic                                   has_pin;
   logic                                   net_end;
   logic                                   design_end;

   modport source (
      output valid, node_x, node_y, pin_dx, pin_dy, has_pin, net_end, design_end,
      input  ready
   );
   modport sink (
      input  valid, node_x, node_y, pin_dx, pin_dy, has_pin, net_end, design_end,
      output ready
   );
endinterface

// Result item channel
interface thpwl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [thpwl_pkg::HPWL_OUT_BITS-1:0]  net_hpwl;
   logic [thpwl_pkg::SITES_BITS-1:0]     total_sites;
   logic                                 total_valid;
   logic                                 total_saturated;

   modport source (
      output valid, net_hpwl, total_sites, total_valid, total_saturated,
      input  ready
   );
   modport sink (
      input  valid, net_hpwl, total_sites, total_valid, total_saturated,
      output ready
   );
endinterface

@@ hw/rtl/thpwl_fifo.sv @@
module thpwl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CntBits'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/thpwl_div.sv @@
// Restoring divider, one quotient bit per cycle
module thpwl_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [thpwl_pkg::TOTAL_BITS-1:0]   dividend,
   input  logic [thpwl_pkg::SITE_W_BITS-1:0]  divisor,
   output logic                               done,
   output logic [thpwl_pkg::TOTAL_BITS-1:0]   quotient
);

   localparam int NumBits = thpwl_pkg::TOTAL_BITS;
   localparam int DivBits = thpwl_pkg::SITE_W_BITS;
   localparam int CntBits = $clog2(NumBits);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [NumBits-1:0] work_ff, work_in;
   logic [DivBits-1:0] rem_ff, rem_in;
   logic [DivBits-1:0] dsr_ff, dsr_in;
   logic [DivBits:0]   trial;
   logic [DivBits:0]   diff;
   logic               fits;

   assign trial    = {rem_ff, work_ff[NumBits-1]};
   assign diff     = trial - {1'b0, dsr_ff};
   assign fits     = (trial >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = work_ff;

   // Shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DivBits-1:0] : trial[DivBits-1:0];
         work_in = {work_ff[NumBits-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(NumBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

endmodule

@@ hw/rtl/thpwl_front.sv @@
// Front end: takes pin items, forms absolute pin position, classifies the item
module thpwl_front #(
   parameter int COORD_BITS = 31,
   parameter int POS_BITS   = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   thpwl_req_if.sink                                     req_ch,
   output logic                                          push,
   output logic [thpwl_pkg::FLAG_BITS+2*POS_BITS-1:0]    push_data,
   input  logic                                          queue_full
);

   logic                          stage_valid_ff, stage_valid_in;
   thpwl_pkg::item_flags_type     flags_ff, flags_in;
   logic signed [POS_BITS-1:0]    pos_x_ff, pos_x_in;
   logic signed [POS_BITS-1:0]    pos_y_ff, pos_y_in;
   logic                          accept;

   assign req_ch.ready = !stage_valid_ff || !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = stage_valid_ff;
   assign push_data    = {flags_ff, pos_x_ff, pos_y_ff};

   // Absolute position; design end also closes the net
   always_comb begin
      pos_x_in = POS_BITS'(req_ch.node_x) + POS_BITS'(req_ch.pin_dx);
      pos_y_in = POS_BITS'(req_ch.node_y) + POS_BITS'(req_ch.pin_dy);
      flags_in.has_pin    = req_ch.has_pin;
      flags_in.net_close  = req_ch.net_end || req_ch.design_end;
      flags_in.design_end = req_ch.design_end;
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (!queue_full) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff <= flags_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

endmodule

@@ hw/rtl/thpwl_back.sv @@
// Back end: bounding box, net wirelength, saturating total, site division
module thpwl_back #(
   parameter int POS_BITS = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [thpwl_pkg::SITE_W_BITS-1:0]             site_pitch,
   input  logic                                          pop_valid,
   input  logic [thpwl_pkg::FLAG_BITS+2*POS_BITS-1:0]    pop_data,
   output logic                                          pop,
   thpwl_rsp_if.source                                   rsp_ch
);

   localparam int HpwlBits = POS_BITS + 1;
   localparam int WideBits = (HpwlBits > thpwl_pkg::HPWL_OUT_BITS) ?
                             HpwlBits : thpwl_pkg::HPWL_OUT_BITS;
   localparam int TotBits  = thpwl_pkg::TOTAL_BITS;
   localparam int SiteBits = thpwl_pkg::SITES_BITS;

   localparam logic [2:0] ST_PIN    = 3'd0;
   localparam logic [2:0] ST_DIFF   = 3'd1;
   localparam logic [2:0] ST_SUM    = 3'd2;
   localparam logic [2:0] ST_ACC    = 3'd3;
   localparam logic [2:0] ST_DSTART = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic                        seen_ff, seen_in;
   logic                        de_ff, de_in;
   logic                        clip_ff, clip_in;
   logic [TotBits-1:0]          total_ff, total_in;
   logic signed [POS_BITS-1:0]  box_xl_ff, box_xl_in, box_xh_ff, box_xh_in;
   logic signed [POS_BITS-1:0]  box_yl_ff, box_yl_in, box_yh_ff, box_yh_in;
   logic [POS_BITS-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic [HpwlBits-1:0]         hpwl_ff, hpwl_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [thpwl_pkg::HPWL_OUT_BITS-1:0]   net_hpwl_ff;
   logic [SiteBits-1:0]                   sites_ff;
   logic                                  tvalid_ff;
   logic                                  tsat_ff;

   thpwl_pkg::item_flags_type   item_flags;
   logic signed [POS_BITS-1:0]  pin_x, pin_y;
   logic [TotBits:0]            sum_wide;
   logic [WideBits-1:0]         hpwl_wide;
   logic [thpwl_pkg::HPWL_OUT_BITS-1:0] hpwl_out;
   logic [SiteBits-1:0]         sites_out;
   logic                        load;
   logic                        div_start, div_done;
   logic [TotBits-1:0]          div_quot;
   logic [thpwl_pkg::SITE_W_BITS-1:0] divisor;

   assign {item_flags, pin_x, pin_y} = pop_data;
   assign divisor   = (site_pitch == '0) ? thpwl_pkg::SITE_W_RESET : site_pitch;
   assign sum_wide  = {1'b0, total_ff} + (TotBits + 1)'(hpwl_ff);
   assign hpwl_wide = WideBits'(hpwl_ff);
   assign hpwl_out  = (hpwl_wide > WideBits'(thpwl_pkg::HPWL_MAX)) ?
                      thpwl_pkg::HPWL_MAX : hpwl_wide[thpwl_pkg::HPWL_OUT_BITS-1:0];
   assign sites_out = div_quot[TotBits-1] ? thpwl_pkg::SITES_MAX : div_quot[SiteBits-1:0];

   thpwl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      de_in     = de_ff;
      clip_in   = clip_ff;
      total_in  = total_ff;
      box_xl_in = box_xl_ff;
      box_xh_in = box_xh_ff;
      box_yl_in = box_yl_ff;
      box_yh_in = box_yh_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      hpwl_in   = hpwl_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_PIN: begin
            if (pop_valid) begin
               pop = 1'b1;
               if (item_flags.has_pin) begin
                  if (!seen_ff || pin_x < box_xl_ff) box_xl_in = pin_x;
                  if (!seen_ff || pin_x > box_xh_ff) box_xh_in = pin_x;
                  if (!seen_ff || pin_y < box_yl_ff) box_yl_in = pin_y;
                  if (!seen_ff || pin_y > box_yh_ff) box_yh_in = pin_y;
                  seen_in = 1'b1;
               end
               if (item_flags.net_close) begin
                  de_in    = item_flags.design_end;
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            // box span; modulo subtraction gives the exact nonnegative span
            dx_in    = seen_ff ? POS_BITS'(box_xh_ff - box_xl_ff) : '0;
            dy_in    = seen_ff ? POS_BITS'(box_yh_ff - box_yl_ff) : '0;
            seen_in  = 1'b0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            hpwl_in  = {1'b0, dx_ff} + {1'b0, dy_ff};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sum_wide[TotBits]) begin
               total_in = thpwl_pkg::TOTAL_MAX;
               clip_in  = 1'b1;
            end else begin
               total_in = sum_wide[TotBits-1:0];
            end
            state_in = de_ff ? ST_DSTART : ST_OUT;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load = 1'b1;
               if (de_ff) begin
                  total_in = '0;
                  clip_in  = 1'b0;
               end
               state_in = ST_PIN;
            end
         end
         default: begin
            state_in = ST_PIN;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIN;
         seen_ff      <= 1'b0;
         de_ff        <= 1'b0;
         clip_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         de_ff        <= de_in;
         clip_ff      <= clip_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      box_xl_ff <= box_xl_in;
      box_xh_ff <= box_xh_in;
      box_yl_ff <= box_yl_in;
      box_yh_ff <= box_yh_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      hpwl_ff   <= hpwl_in;
      if (load) begin
         net_hpwl_ff <= hpwl_out;
         sites_ff    <= de_ff ? sites_out : '0;
         tvalid_ff   <= de_ff;
         tsat_ff     <= clip_ff || (de_ff && div_quot[TotBits-1]);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.net_hpwl        = net_hpwl_ff;
   assign rsp_ch.total_sites     = sites_ff;
   assign rsp_ch.total_valid     = tvalid_ff;
   assign rsp_ch.total_saturated = tsat_ff;

endmodule

@@ hw/rtl/total_hpwl_in_sites.sv @@
// Throughput: one pin item per cycle while the pin queue is not full; an item that closes
// a net holds the back end through its span, sum, accumulate and output states, a design
// end also through a serial divide of the total by the site width.
// The pin queue lets the front end keep taking items while the back end works.
// Reset (synchronous, active high) empties the queue, clears the total and its
// clipped flag, drops any pending result and sets the site pitch to 1.
module total_hpwl_in_sites #(
   parameter int COORD_BITS = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [thpwl_pkg::SITE_W_BITS-1:0]  csr_wr_data,
   thpwl_req_if.sink                          req_ch,
   thpwl_rsp_if.source                        rsp_ch
);

   localparam int PosBits   = ((COORD_BITS > thpwl_pkg::OFFSET_BITS) ?
                               COORD_BITS : thpwl_pkg::OFFSET_BITS) + 1;
   localparam int EntryBits = thpwl_pkg::FLAG_BITS + 2 * PosBits;

   logic [thpwl_pkg::SITE_W_BITS-1:0] site_pitch_ff;
   logic                              q_push, q_full, q_pop, q_not_empty;
   logic [EntryBits-1:0]              q_push_data, q_pop_data;

   // Site width register
   always_ff @(posedge clock) begin
      if (reset) begin
         site_pitch_ff <= thpwl_pkg::SITE_W_RESET;
      end else if (csr_wr_en) begin
         site_pitch_ff <= csr_wr_data;
      end
   end

   thpwl_front #(
      .COORD_BITS (COORD_BITS),
      .POS_BITS   (PosBits)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push       (q_push),
      .push_data  (q_push_data),
      .queue_full (q_full)
   );

   thpwl_fifo #(
      .WIDTH (EntryBits),
      .DEPTH (thpwl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   thpwl_back #(
      .POS_BITS (PosBits)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .site_pitch (site_pitch_ff),
      .pop_valid  (q_not_empty),
      .pop_data   (q_pop_data),
      .pop        (q_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
